// File: hw/rtl/mlr_pkg.sv
// mlr_pkg: shared types, widths and the microcode table of the midpoint line rasterizer
// used by mlr_datapath and midpoint_line_rasterizer; depends on nothing else
package mlr_pkg;

	localparam int COORD_BITS  = 6;
	localparam int DEC_BITS    = COORD_BITS + 3;
	localparam int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic signed [DEC_BITS-1:0] dec_t;

	typedef enum logic [1:0] {
		STEP_LOAD,
		STEP_DIFF,
		STEP_INIT,
		STEP_EMIT
	} step_t;

	typedef enum logic [1:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_LAST,
		COND_NOT_LAST
	} cond_t;

	typedef struct packed {
		logic  in_ready;
		logic  out_valid;
		logic  load;
		logic  diff;
		logic  init;
		logic  adv;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		logic load_en;
		logic diff_en;
		logic init_en;
		logic adv_en;
	} dp_ctrl_t;

	typedef struct packed {
		logic last;
	} dp_stat_t;

	// program: load a request, form deltas, seed decision, emit until last
	// falling through the emit step wraps back to the load step
	function automatic ctrl_word_t ucode_rom(step_t s);
		ctrl_word_t w;
		w = '0;
		unique case (s)
			STEP_LOAD: begin
				w.in_ready = 1'b1;
				w.load     = 1'b1;
				w.cond     = COND_NEVER;
				w.target   = STEP_LOAD;
			end
			STEP_DIFF: begin
				w.diff   = 1'b1;
				w.cond   = COND_NEVER;
				w.target = STEP_LOAD;
			end
			STEP_INIT: begin
				w.init   = 1'b1;
				w.cond   = COND_NEVER;
				w.target = STEP_LOAD;
			end
			STEP_EMIT: begin
				w.out_valid = 1'b1;
				w.adv       = 1'b1;
				w.cond      = COND_NOT_LAST;
				w.target    = STEP_EMIT;
			end
			default: begin
				w = '0;
			end
		endcase
		return w;
	endfunction

endpackage

// File: hw/rtl/mlr_datapath.sv
// mlr_datapath: coordinate, delta and decision registers of the line rasterizer
// driven by control enables from the sequencer; depends on mlr_pkg
module mlr_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  mlr_pkg::dp_ctrl_t   ctrl,
	input  mlr_pkg::coord_t     x_start,
	input  mlr_pkg::coord_t     y_start,
	input  mlr_pkg::coord_t     x_end,
	input  mlr_pkg::coord_t     y_end,
	output mlr_pkg::coord_t     pixel_x,
	output mlr_pkg::coord_t     pixel_y,
	output mlr_pkg::dp_stat_t   stat
);

	mlr_pkg::coord_t cur_x_q, cur_y_q, end_x_q, end_y_q;
	mlr_pkg::coord_t adx_q, ady_q, remaining_q;
	mlr_pkg::dec_t   decision_q, inc_straight_q, inc_diagonal_q;
	logic            dir_x_neg_q, dir_y_neg_q, y_major_q;

	mlr_pkg::coord_t major, minor, next_x, next_y, step_x, step_y;
	mlr_pkg::dec_t   minor2, major2, major_ext;
	logic            straight;

	always_comb begin
		major     = y_major_q ? ady_q : adx_q;
		minor     = y_major_q ? adx_q : ady_q;
		minor2    = mlr_pkg::dec_t'(minor) <<< 1;
		major_ext = mlr_pkg::dec_t'(major);
		major2    = major_ext <<< 1;
		straight  = decision_q[mlr_pkg::DEC_BITS-1] || (decision_q == '0);
		step_x    = dir_x_neg_q ? (cur_x_q - mlr_pkg::coord_t'(1))
		                        : (cur_x_q + mlr_pkg::coord_t'(1));
		step_y    = dir_y_neg_q ? (cur_y_q - mlr_pkg::coord_t'(1))
		                        : (cur_y_q + mlr_pkg::coord_t'(1));
		// major axis always advances, minor only on a diagonal step
		next_x    = (!y_major_q || !straight) ? step_x : cur_x_q;
		next_y    = (y_major_q || !straight) ? step_y : cur_y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q        <= '0;
			cur_y_q        <= '0;
			end_x_q        <= '0;
			end_y_q        <= '0;
			adx_q          <= '0;
			ady_q          <= '0;
			remaining_q    <= '0;
			decision_q     <= '0;
			inc_straight_q <= '0;
			inc_diagonal_q <= '0;
			dir_x_neg_q    <= 1'b0;
			dir_y_neg_q    <= 1'b0;
			y_major_q      <= 1'b0;
		end else begin
			if (ctrl.load_en) begin
				cur_x_q <= x_start;
				cur_y_q <= y_start;
				end_x_q <= x_end;
				end_y_q <= y_end;
			end
			if (ctrl.diff_en) begin
				dir_x_neg_q <= end_x_q < cur_x_q;
				dir_y_neg_q <= end_y_q < cur_y_q;
				adx_q       <= (end_x_q < cur_x_q) ? (cur_x_q - end_x_q) : (end_x_q - cur_x_q);
				ady_q       <= (end_y_q < cur_y_q) ? (cur_y_q - end_y_q) : (end_y_q - cur_y_q);
			end
			if (ctrl.init_en) begin
				// y_major was settled in the diff step
				decision_q     <= minor2 - major_ext;
				inc_straight_q <= minor2;
				inc_diagonal_q <= minor2 - major2;
				remaining_q    <= major;
			end
			if (ctrl.diff_en) begin
				y_major_q <= ((end_y_q < cur_y_q) ? (cur_y_q - end_y_q) : (end_y_q - cur_y_q))
				           > ((end_x_q < cur_x_q) ? (cur_x_q - end_x_q) : (end_x_q - cur_x_q));
			end
			if (ctrl.adv_en) begin
				decision_q  <= decision_q + (straight ? inc_straight_q : inc_diagonal_q);
				cur_x_q     <= next_x;
				cur_y_q     <= next_y;
				remaining_q <= remaining_q - mlr_pkg::coord_t'(1);
			end
		end
	end

	assign pixel_x   = cur_x_q;
	assign pixel_y   = cur_y_q;
	assign stat.last = (remaining_q == '0);

endmodule

// File: hw/rtl/midpoint_line_rasterizer.sv
// midpoint_line_rasterizer: top level, microcoded sequencer around mlr_datapath
// depends on mlr_pkg and mlr_datapath
//
// usage:
// the slave channel takes one line request per word: start and end pixel
// coordinates. the master channel returns every pixel of the line in order
// from start to end, one word per pixel, with tlast on the end point.
// a line gives max(|dx|,|dy|)+1 pixel words; a zero-length line gives one.
// timing: a request is taken in the load step, then the diff step forms the
// deltas and the init step seeds the decision term, so the first pixel is
// valid in the emit step that follows. after that one pixel leaves per cycle
// while tready is high, and the sequencer is back in the load step in the
// cycle after the last pixel is taken; a line has 64 pixels at most.
// the order is set by the four-step microcode program, one request at a time.
// reset puts the step counter on the load step with tvalid low.
// a stalled receiver holds the current pixel on tdata and the program
// in the emit step until the word is taken.
module midpoint_line_rasterizer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// x_start, y_start, x_end, y_end
	input  logic [mlr_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// pixel_x, pixel_y, zero pad
	output logic [mlr_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                m_tlast
);

	localparam int CB = mlr_pkg::COORD_BITS;

	mlr_pkg::step_t      step_q, step_next;
	mlr_pkg::ctrl_word_t uw;
	mlr_pkg::dp_ctrl_t   dp_ctrl;
	mlr_pkg::dp_stat_t   dp_stat;
	mlr_pkg::coord_t     pixel_x, pixel_y;
	logic                hold, cond_met;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mlr_pkg::STEP_LOAD;
		end else begin
			step_q <= step_next;
		end
	end

	always_comb begin
		uw   = mlr_pkg::ucode_rom(step_q);
		hold = (uw.in_ready && !s_tvalid) || (uw.out_valid && !m_tready);
		unique case (uw.cond)
			mlr_pkg::COND_NEVER:    cond_met = 1'b0;
			mlr_pkg::COND_ALWAYS:   cond_met = 1'b1;
			mlr_pkg::COND_LAST:     cond_met = dp_stat.last;
			mlr_pkg::COND_NOT_LAST: cond_met = !dp_stat.last;
			default:                cond_met = 1'b0;
		endcase
		priority if (hold) begin
			step_next = step_q;
		end else if (cond_met) begin
			step_next = uw.target;
		end else begin
			step_next = mlr_pkg::step_t'(step_q + 2'd1);
		end
		dp_ctrl.load_en = uw.load && s_tvalid;
		dp_ctrl.diff_en = uw.diff;
		dp_ctrl.init_en = uw.init;
		dp_ctrl.adv_en  = uw.adv && m_tready && !dp_stat.last;
	end

	mlr_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (dp_ctrl),
		.x_start (s_tdata[CB-1:0]),
		.y_start (s_tdata[2*CB-1:CB]),
		.x_end   (s_tdata[3*CB-1:2*CB]),
		.y_end   (s_tdata[4*CB-1:3*CB]),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.stat    (dp_stat)
	);

	assign s_tready = uw.in_ready;
	assign m_tvalid = uw.out_valid;
	assign m_tdata  = mlr_pkg::OUT_TDATA_W'({pixel_y, pixel_x});
	assign m_tlast  = dp_stat.last;

endmodule
